>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the reorder buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SRB_ASSERT_IMPLY(name, ck, rs, pre, post, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SRB_ASSERT_NEXT(name, ck, rs, pre, post, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/srb_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package srb_pkg;

  localparam int DEPTH_DEF        = 32;
  localparam int EARLY_WINDOW_DEF = 16;

  localparam logic [4:0] CAP_RESET   = 5'd30;
  localparam logic [5:0] READY_RESET = 6'(12000 / 1000);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY    = 2'd1;

  // operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // ready flag updates
  localparam logic [2:0] RDY_KEEP   = 3'd0;
  localparam logic [2:0] RDY_SET_EQ = 3'd1;
  localparam logic [2:0] RDY_SET_GE = 3'd2;
  localparam logic [2:0] RDY_CLR    = 3'd3;
  localparam logic [2:0] RDY_CLR_LT = 3'd4;

  // write data source
  localparam logic WR_ITEM  = 1'b0;
  localparam logic WR_RDATA = 1'b1;

  typedef struct packed {
    logic       cap_in;
    logic       rd_en;
    logic       wr_en;
    logic       wr_src;
    logic       hd_inc;
    logic       hd_dec;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic [2:0] rdy_op;
    logic       acc_set;
    logic       pop_set;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cnt_zero;
    logic       can_push;
    logic       newer;
    logic       older;
    logic       equal;
    logic       far;
    logic       out_free;
  } sts_t;

endpackage

>>> rtl/srb_ctrl.sv
// Controller state machine: sequences reads, writes and shifts per item.
module srb_ctrl #(
  parameter int DEPTH = srb_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  srb_pkg::sts_t              sts,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  output srb_pkg::cmd_t              cmd,
  output logic [$clog2(DEPTH)-1:0]   rd_pos,
  output logic [$clog2(DEPTH)-1:0]   wr_pos
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_TAIL  = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_PUTH  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_PUTM  = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]    state, state_next;
  logic [IW-1:0] i, i_next, j, j_next;
  logic [IW-1:0] i_inc, cnt_last, cnt_pos;

  assign i_inc    = i + IW'(1);
  assign cnt_last = IW'(count - CW'(1));
  assign cnt_pos  = IW'(count);
  assign in_stall = rst | (state != S_IDLE);

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    cmd        = '0;
    rd_pos     = '0;
    wr_pos     = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.cap_in = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_FIN;
        unique case (sts.op)
          srb_pkg::OP_APPEND: begin
            if (sts.can_push) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = srb_pkg::WR_ITEM;
              wr_pos      = cnt_pos;
              cmd.cnt_inc = 1'b1;
              cmd.rdy_op  = srb_pkg::RDY_SET_EQ;
              cmd.acc_set = 1'b1;
            end
          end
          srb_pkg::OP_INSERT: begin
            if (sts.can_push && sts.cnt_zero) begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = srb_pkg::WR_ITEM;
              wr_pos      = '0;
              cmd.cnt_inc = 1'b1;
              cmd.rdy_op  = srb_pkg::RDY_CLR;
              cmd.acc_set = 1'b1;
            end else if (sts.can_push) begin
              cmd.rdy_op = srb_pkg::RDY_SET_GE;
              cmd.rd_en  = 1'b1;
              rd_pos     = cnt_last;
              state_next = S_TAIL;
            end
          end
          srb_pkg::OP_POP: begin
            if (!sts.cnt_zero) begin
              cmd.rd_en  = 1'b1;
              rd_pos     = '0;
              state_next = S_POP;
            end
          end
          srb_pkg::OP_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            cmd.rdy_op  = srb_pkg::RDY_CLR;
          end
        endcase
      end
      S_TAIL: begin
        if (sts.newer) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_src  = srb_pkg::WR_ITEM;
          wr_pos      = cnt_pos;
          cmd.cnt_inc = 1'b1;
          cmd.acc_set = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_pos     = '0;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        priority if (sts.older) begin
          if (sts.far) begin
            state_next = S_FIN;
          end else begin
            cmd.hd_dec = 1'b1;
            state_next = S_PUTH;
          end
        end else if (sts.equal) begin
          state_next = S_FIN;
        end else if (count > CW'(1)) begin
          i_next     = IW'(1);
          cmd.rd_en  = 1'b1;
          rd_pos     = IW'(1);
          state_next = S_SCAN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_PUTH: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = srb_pkg::WR_ITEM;
        wr_pos      = '0;
        cmd.cnt_inc = 1'b1;
        cmd.acc_set = 1'b1;
        state_next  = S_FIN;
      end
      S_SCAN: begin
        priority if (sts.equal) begin
          state_next = S_FIN;
        end else if (sts.older) begin
          j_next     = cnt_last;
          cmd.rd_en  = 1'b1;
          rd_pos     = cnt_last;
          state_next = S_SHIFT;
        end else if (CW'(i_inc) < count) begin
          i_next    = i_inc;
          cmd.rd_en = 1'b1;
          rd_pos    = i_inc;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = srb_pkg::WR_RDATA;
        wr_pos     = j + IW'(1);
        if (j == i) begin
          state_next = S_PUTM;
        end else begin
          j_next    = j - IW'(1);
          cmd.rd_en = 1'b1;
          rd_pos    = j - IW'(1);
        end
      end
      S_PUTM: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = srb_pkg::WR_ITEM;
        wr_pos      = i;
        cmd.cnt_inc = 1'b1;
        cmd.acc_set = 1'b1;
        state_next  = S_FIN;
      end
      S_POP: begin
        cmd.hd_inc  = 1'b1;
        cmd.cnt_dec = 1'b1;
        cmd.rdy_op  = srb_pkg::RDY_CLR_LT;
        cmd.acc_set = 1'b1;
        cmd.pop_set = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
  end

endmodule

>>> rtl/srb_dpath.sv
// Datapath: descriptor memory, head and count, ready flag, registers, result register.
module srb_dpath #(
  parameter int DEPTH        = srb_pkg::DEPTH_DEF,
  parameter int EARLY_WINDOW = srb_pkg::EARLY_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  srb_pkg::cmd_t                   cmd,
  input  logic [$clog2(DEPTH)-1:0]        rd_pos,
  input  logic [$clog2(DEPTH)-1:0]        wr_pos,
  output srb_pkg::sts_t                   sts,
  output logic [$clog2(DEPTH+1)-1:0]      count,
  input  logic [1:0]                      op,
  input  logic [15:0]                     seq,
  input  logic [31:0]                     payload_ref,
  input  logic [15:0]                     payload_len,
  input  logic                            cfg_we,
  input  logic [srb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic                            accepted,
  output logic [15:0]                     out_seq,
  output logic [31:0]                     out_ref,
  output logic [15:0]                     out_len,
  output logic [5:0]                      fill_count,
  output logic                            ready_res
);

  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > 6) ? CW : 6;
  localparam logic [IW:0] DEPTH_X = (IW + 1)'(DEPTH);
  localparam logic [16:0] EW_X    = 17'(EARLY_WINDOW);

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] pref;
    logic [15:0] len;
  } entry_t;

  entry_t        mem [DEPTH];
  entry_t        rdata, item, wdata;
  logic [1:0]    item_op;
  logic [IW-1:0] hd, rd_addr, wr_addr;
  logic [4:0]    cap, cap_next;
  logic [5:0]    level, level_next;
  logic          ready, ready_next;
  logic          acc, pop_hit;
  logic [15:0]   diff, behind;
  logic [CW-1:0] count_plus, count_minus;

  function automatic logic [IW-1:0] to_phys(input logic [IW-1:0] pos,
                                            input logic [IW-1:0] base);
    logic [IW:0] sum;
    sum = {1'b0, pos} + {1'b0, base};
    if (sum >= DEPTH_X) sum = sum - DEPTH_X;
    return sum[IW-1:0];
  endfunction

  assign rd_addr = to_phys(rd_pos, hd);
  assign wr_addr = to_phys(wr_pos, hd);
  assign wdata   = (cmd.wr_src == srb_pkg::WR_RDATA) ? rdata : item;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      item_op <= op;
      item    <= '{seq: seq, pref: payload_ref, len: payload_len};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_addr] <= wdata;
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  // head pointer wraps at DEPTH, which need not be a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      hd <= '0;
    end else if (cmd.hd_inc) begin
      hd <= (hd == IW'(DEPTH - 1)) ? '0 : hd + IW'(1);
    end else if (cmd.hd_dec) begin
      hd <= (hd == '0) ? IW'(DEPTH - 1) : hd - IW'(1);
    end
  end

  assign count_plus  = count + CW'(1);
  assign count_minus = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count_plus;
    end else if (cmd.cnt_dec) begin
      count <= count_minus;
    end
  end

  always_comb begin
    ready_next = ready;
    level_next = level;
    cap_next   = cap;
    unique case (cmd.rdy_op)
      srb_pkg::RDY_KEEP: ;
      srb_pkg::RDY_SET_EQ:
        if (CMP_W'(count_plus) == CMP_W'(level)) ready_next = 1'b1;
      srb_pkg::RDY_SET_GE:
        if (CMP_W'(count) >= CMP_W'(level)) ready_next = 1'b1;
      srb_pkg::RDY_CLR:
        ready_next = 1'b0;
      srb_pkg::RDY_CLR_LT:
        if (CMP_W'(count_minus) < CMP_W'(level)) ready_next = 1'b0;
      default: ;
    endcase
    if (cfg_we) begin
      unique case (cfg_index)
        srb_pkg::CFG_CAPACITY: cap_next = cfg_data[4:0];
        srb_pkg::CFG_READY: begin
          if (cfg_data != '0) begin
            if (cfg_data > level) ready_next = 1'b0;
            level_next = cfg_data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready <= 1'b0;
      level <= srb_pkg::READY_RESET;
      cap   <= srb_pkg::CAP_RESET;
    end else begin
      ready <= ready_next;
      level <= level_next;
      cap   <= cap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= 1'b0;
      pop_hit <= 1'b0;
    end else if (cmd.cap_in) begin
      acc     <= 1'b0;
      pop_hit <= 1'b0;
    end else begin
      if (cmd.acc_set) acc <= 1'b1;
      if (cmd.pop_set) pop_hit <= 1'b1;
    end
  end

  assign diff   = item.seq - rdata.seq;
  assign behind = rdata.seq - item.seq;

  always_comb begin
    sts.op       = item_op;
    sts.cnt_zero = (count == '0);
    sts.can_push = (CMP_W'(count) <= CMP_W'(cap)) && (count < CW'(DEPTH));
    sts.newer    = (diff != '0) && !diff[15];
    sts.older    = diff[15];
    sts.equal    = (diff == '0);
    sts.far      = {1'b0, behind} > EW_X;
    sts.out_free = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted   <= acc;
      out_seq    <= pop_hit ? rdata.seq  : '0;
      out_ref    <= pop_hit ? rdata.pref : '0;
      out_len    <= pop_hit ? rdata.len  : '0;
      fill_count <= 6'(count);
      ready_res  <= ready;
    end
  end

endmodule

>>> rtl/sequence_reorder_buffer.sv
// Top level of the packet sequence reorder buffer.
// Holds up to DEPTH packet descriptors (sequence number, payload reference,
// length) in sequence order in a circular single-port-write, single-port-read
// memory, and runs one operation per input item: append at the tail, sorted
// insert by 16-bit wrapping sequence number, pop of the head, or clear. Every
// item gives exactly one result item with the popped descriptor (zero when
// nothing is popped), the accepted bit, the fill count and the playout ready
// flag. Items are handled one at a time. The memory gives one read and one
// write a cycle, and the search and the shift of the newer entries in a
// middle insert each move through it one entry a cycle. A finished result
// waits in an output register, so the next item is taken while it is
// still stalled. Both channels accept an item on a clock edge with valid high
// and stall low. Configuration writes (index 0 capacity limit, index 1 ready
// level; other indexes do nothing) are always ready and must be issued while
// no item is in flight. No clearing pass follows reset: entries are only
// read below the fill count.
module sequence_reorder_buffer #(
  parameter int DEPTH        = srb_pkg::DEPTH_DEF,
  parameter int EARLY_WINDOW = srb_pkg::EARLY_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      op,
  input  logic [15:0]                     seq,
  input  logic [31:0]                     payload_ref,
  input  logic [15:0]                     payload_len,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            accepted,
  output logic [15:0]                     out_seq,
  output logic [31:0]                     out_ref,
  output logic [15:0]                     out_len,
  output logic [5:0]                      fill_count,
  output logic                            ready_res,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  srb_pkg::cmd_t cmd;
  srb_pkg::sts_t sts;
  logic [IW-1:0] rd_pos, wr_pos;
  logic [CW-1:0] count;
  logic          cfg_we;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  srb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .count    (count),
    .cmd      (cmd),
    .rd_pos   (rd_pos),
    .wr_pos   (wr_pos)
  );

  srb_dpath #(
    .DEPTH        (DEPTH),
    .EARLY_WINDOW (EARLY_WINDOW)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_pos      (rd_pos),
    .wr_pos      (wr_pos),
    .sts         (sts),
    .count       (count),
    .op          (op),
    .seq         (seq),
    .payload_ref (payload_ref),
    .payload_len (payload_len),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .accepted    (accepted),
    .out_seq     (out_seq),
    .out_ref     (out_ref),
    .out_len     (out_len),
    .fill_count  (fill_count),
    .ready_res   (ready_res)
  );

endmodule

>>> rtl/srb_checker.sv
// Port-level assertions for the reorder buffer, bound to the top level.
`include "assert_macros.svh"

module srb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        accepted,
  input logic [15:0] out_seq,
  input logic [31:0] out_ref,
  input logic [15:0] out_len,
  input logic [5:0]  fill_count,
  input logic        ready_res
);

  // one item in flight: taking an item closes the input at once
  `SRB_ASSERT_NEXT(a_one_in_flight, clk, rst, (in_valid && !in_stall), in_stall, "item taken while busy")

  // an item that is not accepted gives zero descriptor fields
  `SRB_ASSERT_IMPLY(a_zero_fields, clk, rst, (out_valid && !accepted), (out_seq == 16'd0 && out_ref == 32'd0 && out_len == 16'd0), "descriptor fields set without an accepted item")

  // the ready flag never stands over an empty buffer
  `SRB_ASSERT_IMPLY(a_ready_nonempty, clk, rst, (out_valid && ready_res), (fill_count != 6'd0), "ready flag with empty buffer")

  // a stalled result holds
  `SRB_ASSERT_NEXT(a_out_hold, clk, rst, (out_valid && out_stall), (out_valid && $stable(out_seq) && $stable(fill_count) && $stable(accepted)), "stalled result changed")

endmodule

bind sequence_reorder_buffer srb_checker u_srb_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .accepted   (accepted),
  .out_seq    (out_seq),
  .out_ref    (out_ref),
  .out_len    (out_len),
  .fill_count (fill_count),
  .ready_res  (ready_res)
);
